/* src/contiguous_page_allocator_unit_defines.svh */
// Assertion macros used by the allocator sequencer RTL.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CPA_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("cpa: implication check failed");
`define CPA_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("cpa: next-cycle check failed");
`else
`define CPA_ASSERT_IMP(lbl, a, b)
`define CPA_ASSERT_NXT(lbl, a, b)
`endif
`endif

/* src/cpa_pkg.sv */
// Shared types and codes of the contiguous page allocator.
package cpa_pkg;

    localparam int FRAME_W = 20;
    localparam int OWNER_W = 16;
    localparam int ORDER_W = 16;
    localparam int KIND_W  = 3;
    localparam int CNT_W   = 16;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_SWAP  = 2'd2;
    localparam logic [1:0] REQ_COUNT = 2'd3;

    localparam logic [2:0] KIND_NOTICE   = 3'd0;
    localparam logic [2:0] KIND_GRANTED  = 3'd1;
    localparam logic [2:0] KIND_FREED    = 3'd2;
    localparam logic [2:0] KIND_SWAPPED  = 3'd3;
    localparam logic [2:0] KIND_COUNT    = 3'd4;
    localparam logic [2:0] KIND_NOTFOUND = 3'd5;

    localparam logic [1:0] CFG_FIRST_FRAME = 2'd0;
    localparam logic [1:0] CFG_TOTAL_PAGES = 2'd1;
    localparam logic [1:0] CFG_RESERVED    = 2'd2;
    localparam logic [1:0] CFG_FLOOR       = 2'd3;

    localparam logic [8:0] VICTIM_RESET = 9'd15;

    typedef struct packed {
        logic [FRAME_W-1:0] first_frame;
        logic [8:0]         total_pages;
        logic [8:0]         reserved_pages;
        logic [7:0]         victim_floor;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FRAME_W-1:0] frame;
        logic [OWNER_W-1:0] owner;
        logic [ORDER_W-1:0] order;
        logic               last;
    } res_t;

endpackage

/* src/cpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cpa_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/cpa_ctrl.sv */
// Request sequencer: table scan, eviction, grant, free, swap in and count.
`include "contiguous_page_allocator_unit_defines.svh"

module cpa_ctrl #(
    parameter int PAGES   = 256,
    parameter int MAX_RUN = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cpa_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [3:0]                    page_count,
    input  logic [cpa_pkg::FRAME_W-1:0]   frame_number,
    input  logic [cpa_pkg::OWNER_W-1:0]   owner_id,
    input  logic [cpa_pkg::ORDER_W-1:0]   order_value,
    output logic                          res_valid,
    input  logic                          res_ready,
    output cpa_pkg::res_t                 res
);

    localparam int AW  = $clog2(PAGES);
    localparam int NB  = $clog2(PAGES + 1);
    localparam int NW  = (NB > 9 ? NB : 9) + 1;
    localparam int RLW = $clog2(MAX_RUN + 1);
    localparam int EW  = 1 + RLW + cpa_pkg::OWNER_W + cpa_pkg::CNT_W;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_FF_RD   = 4'd2;
    localparam logic [3:0] S_FF_CHK  = 4'd3;
    localparam logic [3:0] S_EV_RD   = 4'd4;
    localparam logic [3:0] S_EV_CHK  = 4'd5;
    localparam logic [3:0] S_EJ_RD   = 4'd6;
    localparam logic [3:0] S_EJ_CHK  = 4'd7;
    localparam logic [3:0] S_G_RD    = 4'd8;
    localparam logic [3:0] S_G_WR    = 4'd9;
    localparam logic [3:0] S_X_RD    = 4'd10;
    localparam logic [3:0] S_X_CHK   = 4'd11;
    localparam logic [3:0] S_F_RD    = 4'd12;
    localparam logic [3:0] S_F_WR    = 4'd13;
    localparam logic [3:0] S_SW_DONE = 4'd14;
    localparam logic [3:0] S_EMIT    = 4'd15;

    logic [3:0]                  state_reg, state_next;
    logic [3:0]                  ret_reg, ret_next;
    logic [NW-1:0]               ptr_reg, ptr_next;
    logic [NW-1:0]               j_reg, j_next;
    logic [NW-1:0]               lim_reg, lim_next;
    logic [NW-1:0]               jend_reg, jend_next;
    logic [NW-1:0]               start_reg, start_next;
    logic [NW-1:0]               vp_reg, vp_next;
    logic [RLW-1:0]              run_reg, run_next;
    logic [RLW-1:0]              k_reg, k_next;
    logic [1:0]                  type_reg, type_next;
    logic [cpa_pkg::FRAME_W-1:0] fn_reg, fn_next;
    logic [cpa_pkg::OWNER_W-1:0] own_reg, own_next;
    logic [cpa_pkg::ORDER_W-1:0] ordv_reg, ordv_next;
    cpa_pkg::res_t               pend_reg, pend_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [NW-1:0] wr_ext;

    logic                        rd_used;
    logic [RLW-1:0]              rd_run;
    logic [cpa_pkg::OWNER_W-1:0] rd_owner;
    logic [cpa_pkg::CNT_W-1:0]   rd_cnt;

    logic [NW-1:0]               n_w, res_w, floor_w, k_w;
    logic [RLW-1:0]              kc;
    logic [cpa_pkg::FRAME_W-1:0] idx20;
    logic [NW-1:0]               s_ev, vp_inc, len_w, end_w;

    cpa_ram #(.WIDTH(EW), .DEPTH(PAGES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_used  = rdata[EW-1];
    assign rd_run   = rdata[EW-2:32];
    assign rd_owner = rdata[31:16];
    assign rd_cnt   = rdata[15:0];

    assign n_w     = (NW'(cfg.total_pages) > NW'(PAGES)) ? NW'(PAGES) : NW'(cfg.total_pages);
    assign res_w   = NW'(cfg.reserved_pages);
    assign floor_w = NW'(cfg.victim_floor);
    assign k_w     = NW'(k_reg);
    assign idx20   = frame_number - cfg.first_frame;
    assign wr_ext  = NW'(waddr);

    always_comb
    begin
        if (page_count == 4'd0)
        begin
            kc = RLW'(1);
        end
        else if (5'(page_count) > 5'(MAX_RUN))
        begin
            kc = RLW'(MAX_RUN);
        end
        else
        begin
            kc = RLW'(page_count);
        end
    end

    // eviction window start and victim pointer step
    always_comb
    begin
        s_ev = vp_reg;
        if (s_ev < res_w)
        begin
            s_ev = res_w;
        end
        if (s_ev + k_w > n_w)
        begin
            s_ev = n_w - k_w;
        end
        vp_inc = vp_reg + NW'(1);
        if (vp_inc >= n_w)
        begin
            vp_inc = '0;
        end
        if (vp_inc < floor_w)
        begin
            vp_inc = floor_w;
        end
    end

    // run length just read, 1..MAX_RUN in eviction, clipped at the table end
    always_comb
    begin
        len_w = NW'(rd_run);
        if (state_reg == S_EV_CHK)
        begin
            if (rd_run == '0)
            begin
                len_w = NW'(1);
            end
            else if (NW'(rd_run) > NW'(MAX_RUN))
            begin
                len_w = NW'(MAX_RUN);
            end
        end
        end_w = ptr_reg + len_w;
        if (end_w > n_w)
        begin
            end_w = n_w;
        end
    end

    assign raddr     = (state_reg == S_EJ_RD) ? AW'(j_reg) : AW'(ptr_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = pend_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ptr_next   = ptr_reg;
        j_next     = j_reg;
        lim_next   = lim_reg;
        jend_next  = jend_reg;
        start_next = start_reg;
        vp_next    = vp_reg;
        run_next   = run_reg;
        k_next     = k_reg;
        type_next  = type_reg;
        fn_next    = fn_reg;
        own_next   = own_reg;
        ordv_next  = ordv_reg;
        pend_next  = pend_reg;
        we         = 1'b0;
        waddr      = AW'(ptr_reg);
        wdata      = {1'b0, rd_run, rd_owner, rd_cnt};

        unique case (state_reg)
            S_CLR:
            begin
                we    = 1'b1;
                wdata = '0;
                ptr_next = ptr_reg + NW'(1);
                if (ptr_reg == NW'(PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    type_next = req_type;
                    fn_next   = frame_number;
                    own_next  = owner_id;
                    ordv_next = order_value;
                    k_next    = kc;
                    ret_next  = S_IDLE;
                    if (req_type == cpa_pkg::REQ_ALLOC)
                    begin
                        if (res_w >= n_w || (n_w - res_w) < NW'(kc))
                        begin
                            pend_next  = '{cpa_pkg::KIND_NOTFOUND, '0, '0, '0, 1'b1};
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            ptr_next   = res_w;
                            run_next   = '0;
                            state_next = S_FF_RD;
                        end
                    end
                    else if (idx20 >= cpa_pkg::FRAME_W'(n_w) ||
                             (req_type == cpa_pkg::REQ_SWAP &&
                              idx20 < cpa_pkg::FRAME_W'(res_w)))
                    begin
                        pend_next  = '{cpa_pkg::KIND_NOTFOUND, frame_number, '0, '0, 1'b1};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ptr_next   = NW'(idx20);
                        state_next = S_X_RD;
                    end
                end
            end
            S_FF_RD:
            begin
                if (ptr_reg >= n_w)
                begin
                    start_next = s_ev;
                    ptr_next   = s_ev;
                    lim_next   = s_ev + k_w;
                    vp_next    = vp_inc;
                    state_next = S_EV_RD;
                end
                else
                begin
                    state_next = S_FF_CHK;
                end
            end
            S_FF_CHK:
            begin
                if (rd_used)
                begin
                    run_next   = '0;
                    ptr_next   = ptr_reg + NW'(1);
                    state_next = S_FF_RD;
                end
                else if (run_reg + RLW'(1) == k_reg)
                begin
                    start_next = ptr_reg + NW'(1) - k_w;
                    ptr_next   = ptr_reg + NW'(1) - k_w;
                    lim_next   = ptr_reg + NW'(1);
                    state_next = S_G_RD;
                end
                else
                begin
                    run_next   = run_reg + RLW'(1);
                    ptr_next   = ptr_reg + NW'(1);
                    state_next = S_FF_RD;
                end
            end
            S_EV_RD:
            begin
                if (ptr_reg >= lim_reg)
                begin
                    ptr_next   = start_reg;
                    state_next = S_G_RD;
                end
                else
                begin
                    state_next = S_EV_CHK;
                end
            end
            S_EV_CHK:
            begin
                if (rd_used)
                begin
                    j_next     = ptr_reg;
                    jend_next  = end_w;
                    state_next = S_EJ_RD;
                end
                else
                begin
                    ptr_next   = ptr_reg + NW'(1);
                    state_next = S_EV_RD;
                end
            end
            S_EJ_RD:
            begin
                if (j_reg >= jend_reg)
                begin
                    ptr_next   = ptr_reg + NW'(1);
                    state_next = S_EV_RD;
                end
                else
                begin
                    state_next = S_EJ_CHK;
                end
            end
            S_EJ_CHK:
            begin
                j_next     = j_reg + NW'(1);
                state_next = S_EJ_RD;
                if (rd_used)
                begin
                    we    = 1'b1;
                    waddr = AW'(j_reg);
                    wdata = {1'b0, RLW'(0), rd_owner,
                             (rd_cnt == '1) ? rd_cnt : rd_cnt + cpa_pkg::CNT_W'(1)};
                    pend_next  = '{cpa_pkg::KIND_NOTICE,
                                   cfg.first_frame + cpa_pkg::FRAME_W'(j_reg),
                                   rd_owner, rd_cnt, 1'b0};
                    ret_next   = S_EJ_RD;
                    state_next = S_EMIT;
                end
            end
            S_G_RD:
            begin
                if (ptr_reg >= lim_reg)
                begin
                    pend_next  = '{cpa_pkg::KIND_GRANTED,
                                   cfg.first_frame + cpa_pkg::FRAME_W'(start_reg),
                                   '0, '0, 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_G_WR;
                end
            end
            S_G_WR:
            begin
                we         = 1'b1;
                wdata      = {1'b1, k_reg, own_reg, rd_cnt};
                ptr_next   = ptr_reg + NW'(1);
                state_next = S_G_RD;
            end
            S_X_RD:
            begin
                state_next = S_X_CHK;
            end
            S_X_CHK:
            begin
                ret_next = S_IDLE;
                unique case (type_reg)
                    cpa_pkg::REQ_FREE:
                    begin
                        lim_next   = end_w;
                        state_next = S_F_RD;
                    end
                    cpa_pkg::REQ_SWAP:
                    begin
                        we    = 1'b1;
                        wdata = {1'b1, RLW'(1), rd_owner, ordv_reg};
                        if (rd_used)
                        begin
                            pend_next  = '{cpa_pkg::KIND_NOTICE, fn_reg, rd_owner,
                                           rd_cnt, 1'b0};
                            ret_next   = S_SW_DONE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_SW_DONE;
                        end
                    end
                    cpa_pkg::REQ_COUNT:
                    begin
                        pend_next  = '{cpa_pkg::KIND_COUNT, fn_reg, '0, rd_cnt, 1'b1};
                        state_next = S_EMIT;
                    end
                    cpa_pkg::REQ_ALLOC:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_F_RD:
            begin
                if (ptr_reg >= lim_reg)
                begin
                    pend_next  = '{cpa_pkg::KIND_FREED, fn_reg, '0, '0, 1'b1};
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_F_WR;
                end
            end
            S_F_WR:
            begin
                we         = 1'b1;
                wdata      = {1'b0, RLW'(0), cpa_pkg::OWNER_W'(0), rd_cnt};
                ptr_next   = ptr_reg + NW'(1);
                state_next = S_F_RD;
            end
            S_SW_DONE:
            begin
                pend_next  = '{cpa_pkg::KIND_SWAPPED, fn_reg, '0, '0, 1'b1};
                ret_next   = S_IDLE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ret_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_IDLE;
            ptr_reg   <= '0;
            vp_reg    <= NW'(cpa_pkg::VICTIM_RESET);
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ptr_reg   <= ptr_next;
            vp_reg    <= vp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        lim_reg   <= lim_next;
        jend_reg  <= jend_next;
        start_reg <= start_next;
        run_reg   <= run_next;
        k_reg     <= k_next;
        type_reg  <= type_next;
        fn_reg    <= fn_next;
        own_reg   <= own_next;
        ordv_reg  <= ordv_next;
        pend_reg  <= pend_next;
    end

    // an accepted request always keeps the sequencer busy for the next cycle
    `CPA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, state_reg != S_IDLE)
    // table updates outside the clearing pass stay inside the active table
    `CPA_ASSERT_IMP(a_write_in_table, we && state_reg != S_CLR, wr_ext < n_w)
    // the result that ends a request carries the last flag
    `CPA_ASSERT_IMP(a_last_on_final, res_valid && res_ready && ret_reg == S_IDLE, res.last)
    // notices never end a request
    `CPA_ASSERT_IMP(a_notice_not_last, res_valid && res.kind == cpa_pkg::KIND_NOTICE,
                    !res.last)

endmodule

/* src/contiguous_page_allocator_unit.sv */
// Contiguous page allocator: first-fit frame table with FIFO eviction, top level.
//
// Each request transaction on the slave stream is handled one table entry at a
// time: the sequencer reads one frame entry of the simple dual-port table RAM,
// waits for its registered read data, then decides. A first-fit alloc scans
// frames from the first unreserved one, then examines frames during eviction
// if nothing fits, then writes each granted frame; free writes each freed
// frame; each result transaction passes through the EMIT state. s_tready is
// high only while the sequencer is idle. Results leave through an output
// register, so the next request may be accepted while the final result still
// waits on m_tready. After reset a clearing pass zeroes all PAGES table entries
// before the first request is taken; configuration writes are accepted at any
// time and must be made while idle.
module contiguous_page_allocator_unit #(
    parameter int PAGES   = 256,
    parameter int MAX_RUN = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [19:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // page_count[3:0], frame_number[23:4], owner_id[39:24], order_value[55:40]
    input  logic [55:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_frame[19:0], result_owner[35:20], result_order[51:36], zero[55:52]
    output logic [55:0] m_tdata,
    // result_kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    cpa_pkg::cfg_t cfg_reg, cfg_next;
    cpa_pkg::res_t res, out_reg;
    logic          res_valid, res_ready;
    logic          ovalid_reg, ovalid_next;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                cpa_pkg::CFG_FIRST_FRAME: cfg_next.first_frame    = cfg_wdata;
                cpa_pkg::CFG_TOTAL_PAGES: cfg_next.total_pages    = cfg_wdata[8:0];
                cpa_pkg::CFG_RESERVED:    cfg_next.reserved_pages = cfg_wdata[8:0];
                cpa_pkg::CFG_FLOOR:       cfg_next.victim_floor   = cfg_wdata[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{20'd0, 9'd256, 9'd2, 8'd15};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cpa_ctrl #(.PAGES(PAGES), .MAX_RUN(MAX_RUN)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (s_tuser),
        .page_count   (s_tdata[3:0]),
        .frame_number (s_tdata[23:4]),
        .owner_id     (s_tdata[39:24]),
        .order_value  (s_tdata[55:40]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register: takes a new result whenever empty or being drained
    assign res_ready   = !ovalid_reg || m_tready;
    assign ovalid_next = res_valid ? 1'b1 : (m_tready ? 1'b0 : ovalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= res_ready ? ovalid_next : ovalid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, out_reg.order, out_reg.owner, out_reg.frame};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

/* tb/tb.sv */
// Testbench for the contiguous page allocator: request stream in, checked result stream out.
module tb;

    localparam int TBL = 256;
    localparam int RUNMAX = 8;
    localparam int CYCLE_LIMIT = 3000000;

    // Expected result transaction, one per m_tdata beat.
    typedef struct {
        logic [2:0]  kind;
        logic [19:0] frame;
        logic [15:0] owner;
        logic [15:0] order;
        logic        last;
    } alloc_res_t;

    // Scoreboard: shadow frame table plus queue of pending results.
    class frame_table_sb;
        logic [19:0] first_frame;
        logic [8:0]  total_pages;
        logic [8:0]  reserved_pages;
        logic [7:0]  victim_floor;
        logic        used [TBL];
        logic [3:0]  run_len [TBL];
        logic [15:0] owner [TBL];
        logic [15:0] swaps [TBL];
        int unsigned victim;
        alloc_res_t  pending [$];
        int          errors;

        function new();
            first_frame = 0;
            total_pages = 256;
            reserved_pages = 2;
            victim_floor = 15;
            victim = 15;
            errors = 0;
            for (int i = 0; i < TBL; i++)
            begin
                used[i] = 0;
                run_len[i] = 0;
                owner[i] = 0;
                swaps[i] = 0;
            end
        endfunction

        function void push(logic [2:0] k, logic [19:0] f, logic [15:0] o,
                           logic [15:0] c, logic l);
            alloc_res_t r;
            r.kind = k;
            r.frame = f;
            r.owner = o;
            r.order = c;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void write_reg(logic [1:0] idx, logic [19:0] val);
            case (idx)
                cpa_pkg::CFG_FIRST_FRAME: first_frame = val;
                cpa_pkg::CFG_TOTAL_PAGES: total_pages = val[8:0];
                cpa_pkg::CFG_RESERVED:    reserved_pages = val[8:0];
                default:                  victim_floor = val[7:0];
            endcase
        endfunction

        function void claim_run(int unsigned s, int unsigned k, logic [15:0] own);
            for (int unsigned i = s; i < s + k; i++)
            begin
                used[i] = 1;
                run_len[i] = k[3:0];
                owner[i] = own;
            end
        endfunction

        function void alloc(logic [3:0] cnt, logic [15:0] own);
            int unsigned n, k, rsv, s, nxt, len;
            bit ok;
            n = (total_pages > TBL) ? TBL : total_pages;
            rsv = reserved_pages;
            k = (cnt == 0) ? 1 : ((cnt > RUNMAX) ? RUNMAX : cnt);
            if (rsv >= n || n - rsv < k)
            begin
                push(cpa_pkg::KIND_NOTFOUND, 0, 0, 0, 1);
                return;
            end
            // first fit
            for (int unsigned i = rsv; i + k <= n; i++)
            begin
                ok = 1;
                for (int unsigned j = i; j < i + k; j++)
                    if (used[j]) ok = 0;
                if (ok)
                begin
                    claim_run(i, k, own);
                    push(cpa_pkg::KIND_GRANTED, 20'(first_frame + i), 0, 0, 1);
                    return;
                end
            end
            // FIFO eviction
            s = victim;
            if (s < rsv) s = rsv;
            if (s + k > n) s = n - k;
            nxt = victim + 1;
            if (nxt >= n) nxt = 0;
            if (nxt < victim_floor) nxt = victim_floor;
            victim = nxt;
            for (int unsigned i = s; i < s + k; i++)
            begin
                if (used[i])
                begin
                    len = run_len[i];
                    if (len == 0) len = 1;
                    if (len > RUNMAX) len = RUNMAX;
                    for (int unsigned j = i; j < i + len && j < n; j++)
                    begin
                        if (used[j])
                        begin
                            push(cpa_pkg::KIND_NOTICE, 20'(first_frame + j), owner[j],
                                 swaps[j], 0);
                            if (swaps[j] != 16'hFFFF) swaps[j]++;
                            used[j] = 0;
                            run_len[j] = 0;
                        end
                    end
                end
            end
            claim_run(s, k, own);
            push(cpa_pkg::KIND_GRANTED, 20'(first_frame + s), 0, 0, 1);
        endfunction

        // Note one accepted request transaction.
        function void note_request(logic [1:0] rt, logic [3:0] cnt, logic [19:0] fn,
                                   logic [15:0] own, logic [15:0] ord);
            int unsigned n, idx;
            logic [19:0] d;
            n = (total_pages > TBL) ? TBL : total_pages;
            d = fn - first_frame;
            idx = d;
            if (rt == cpa_pkg::REQ_ALLOC)
            begin
                alloc(cnt, own);
                return;
            end
            if (idx >= n || (rt == cpa_pkg::REQ_SWAP && idx < reserved_pages))
            begin
                push(cpa_pkg::KIND_NOTFOUND, fn, 0, 0, 1);
                return;
            end
            if (rt == cpa_pkg::REQ_FREE)
            begin
                for (int unsigned i = idx; i < idx + run_len[idx] && i < n; i++)
                begin
                    used[i] = 0;
                    owner[i] = 0;
                    if (i != idx) run_len[i] = 0;
                end
                run_len[idx] = 0;
                push(cpa_pkg::KIND_FREED, fn, 0, 0, 1);
            end
            else if (rt == cpa_pkg::REQ_SWAP)
            begin
                if (used[idx]) push(cpa_pkg::KIND_NOTICE, fn, owner[idx], swaps[idx], 0);
                swaps[idx] = ord;
                run_len[idx] = 1;
                used[idx] = 1;
                push(cpa_pkg::KIND_SWAPPED, fn, 0, 0, 1);
            end
            else
                push(cpa_pkg::KIND_COUNT, fn, 0, swaps[idx], 1);
        endfunction

        // Check one accepted result transaction against the oldest expectation.
        function void check_result(logic [2:0] k, logic [55:0] d, logic l);
            alloc_res_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result kind=%0d frame=%h", k, d[19:0]);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind)
            begin
                $error("result_kind expected %0d actual %0d", e.kind, k);
                errors++;
            end
            if (d[19:0] !== e.frame)
            begin
                $error("result_frame expected %h actual %h", e.frame, d[19:0]);
                errors++;
            end
            if (d[35:20] !== e.owner)
            begin
                $error("result_owner expected %h actual %h", e.owner, d[35:20]);
                errors++;
            end
            if (d[51:36] !== e.order)
            begin
                $error("result_order expected %h actual %h", e.order, d[51:36]);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last expected %0d actual %0d", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [19:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    frame_table_sb sb;
    int          send_idle_pct;   // sender gap chance, percent
    int          recv_stall_pct;  // receiver stall chance, percent
    int          hold_off;        // cycles the receiver must still hold off
    longint      cycles;

    contiguous_page_allocator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls per phase, plus a long hold-off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 0;
        else if (hold_off > 0)
        begin
            m_tready <= 0;
            hold_off <= hold_off - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result check at each accepted result transaction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Write enable drops after each write.
    task automatic write_cfg(logic [1:0] idx, logic [19:0] val);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Offer one request transaction and wait for acceptance; valid stays up
    // for the next request unless an idle gap or a drain follows.
    task automatic send_req(logic [1:0] rt, logic [3:0] cnt, logic [19:0] fn,
                            logic [15:0] own, logic [15:0] ord);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= rt;
        s_tdata <= {ord, own, fn, cnt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(rt, cnt, fn, own, ord);
    endtask

    // Wait for every expected result, then let the sequencer settle.
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // Frame near the managed table, sometimes outside it.
    function automatic logic [19:0] pick_frame();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 85)
            return 20'(sb.first_frame + $urandom_range(sb.total_pages + 1));
        else if (r < 93)
            return 20'(sb.first_frame - 1 - $urandom_range(3));
        return 20'($urandom);
    endfunction

    task automatic rand_reqs(int cnt);
        logic [1:0] rt;
        logic [3:0] pc;
        for (int i = 0; i < cnt; i++)
        begin
            rt = $urandom_range(99) < 45 ? cpa_pkg::REQ_ALLOC : 2'($urandom_range(3));
            pc = $urandom_range(99) < 90 ? 4'($urandom_range(1, 8)) : 4'($urandom);
            send_req(rt, pc, pick_frame(), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: small table so eviction and saturation come quickly.
        write_cfg(cpa_pkg::CFG_TOTAL_PAGES, 20);
        write_cfg(cpa_pkg::CFG_RESERVED, 2);
        write_cfg(cpa_pkg::CFG_FLOOR, 3);
        write_cfg(cpa_pkg::CFG_FIRST_FRAME, 20'hFFFF8);  // table wraps past 2^20
        send_req(cpa_pkg::REQ_ALLOC, 0, 0, 16'h0000, 0);          // count 0 acts as 1
        send_req(cpa_pkg::REQ_ALLOC, 4'hF, 0, 16'hFFFF, 0);       // above max run
        send_req(cpa_pkg::REQ_ALLOC, 8, 0, 16'h1234, 0);
        send_req(cpa_pkg::REQ_ALLOC, 8, 0, 16'h5678, 0);          // no fit, eviction
        send_req(cpa_pkg::REQ_ALLOC, 8, 0, 16'h9ABC, 0);
        send_req(cpa_pkg::REQ_SWAP, 0, 20'hFFFF8, 0, 16'h1111);   // reserved frame
        send_req(cpa_pkg::REQ_SWAP, 0, 20'hFFFFC, 0, 16'hFFFF);   // occupied frame
        send_req(cpa_pkg::REQ_ALLOC, 1, 0, 16'hAAAA, 0);          // single frame, full table, eviction
        send_req(cpa_pkg::REQ_COUNT, 0, 20'hFFFF8, 0, 0);         // count of reserved frame
        send_req(cpa_pkg::REQ_COUNT, 0, 20'hFFFFC, 0, 0);
        send_req(cpa_pkg::REQ_FREE, 0, 20'hFFFFA, 0, 0);
        send_req(cpa_pkg::REQ_FREE, 0, 20'hFFFFA, 0, 0);          // already free
        send_req(cpa_pkg::REQ_FREE, 0, 20'h0000B, 0, 0);          // index 19
        send_req(cpa_pkg::REQ_FREE, 0, 20'h0000C, 0, 0);          // not found
        send_req(cpa_pkg::REQ_COUNT, 0, 20'hFFFF7, 0, 0);         // below table
        send_req(cpa_pkg::REQ_SWAP, 0, 20'hFFFFF, 0, 0);
        drain();
        write_cfg(cpa_pkg::CFG_RESERVED, 18);
        send_req(cpa_pkg::REQ_ALLOC, 3, 0, 1, 0);                 // cannot fit
        send_req(cpa_pkg::REQ_ALLOC, 2, 0, 2, 0);
        drain();
        write_cfg(cpa_pkg::CFG_RESERVED, 256);
        write_cfg(cpa_pkg::CFG_TOTAL_PAGES, 1);
        send_req(cpa_pkg::REQ_ALLOC, 1, 0, 3, 0);
        send_req(cpa_pkg::REQ_COUNT, 0, 20'hFFFF8, 0, 0);
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            write_cfg(cpa_pkg::CFG_FIRST_FRAME, ph == 3 ? 20'hFFFFF : 20'($urandom));
            write_cfg(cpa_pkg::CFG_TOTAL_PAGES,
                      20'(ph == 5 ? 256 : (ph == 6 ? 511 : $urandom_range(4, 40))));
            write_cfg(cpa_pkg::CFG_RESERVED, 20'(ph == 2 ? 0 : $urandom_range(0, 4)));
            write_cfg(cpa_pkg::CFG_FLOOR, 20'(ph == 7 ? 255 : $urandom_range(0, 20)));
            if (ph == 4)
                hold_off <= 400;  // long receiver hold-off while requests flow
            rand_reqs(ph == 5 || ph == 6 ? 20 : 55);
            drain();  // sender pauses until every result has come
        end

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* sim.f */
+incdir+src
src/cpa_pkg.sv
src/cpa_ram.sv
src/cpa_ctrl.sv
src/contiguous_page_allocator_unit.sv
tb/tb.sv
